FILE: src/omf_pkg.sv
package omf_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int OVERSAMPLE_COUNT = 64;
  localparam int DECIMATE_SHIFT   = 3;
  localparam int WINDOW_LEN       = 5;
  localparam int MEDIAN_POS       = 2;

  localparam int CNT_W     = $clog2(OVERSAMPLE_COUNT);
  localparam int ACC_W     = SAMPLE_W + CNT_W;
  localparam int WCOUNT_W  = $clog2(WINDOW_LEN);
  localparam int WIDX_W    = $clog2(WINDOW_LEN - 1);
  localparam int PAIR_CNT  = 9;
  localparam int SLOT_W    = $clog2(WINDOW_LEN);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // Compare-exchange network: slot PAIR_LO[i] takes the smaller value.
  localparam slot_t PAIR_LO [PAIR_CNT] = '{
    slot_t'(0), slot_t'(1), slot_t'(2), slot_t'(3), slot_t'(0),
    slot_t'(1), slot_t'(0), slot_t'(2), slot_t'(1)
  };
  localparam slot_t PAIR_HI [PAIR_CNT] = '{
    slot_t'(4), slot_t'(4), slot_t'(4), slot_t'(4), slot_t'(2),
    slot_t'(3), slot_t'(1), slot_t'(3), slot_t'(2)
  };

endpackage

FILE: src/oversample_median_filter_unit.sv
// Oversampling decimator with a median-of-five filter.
// Input stream (s_axis_*): one 16-bit unsigned sample per transaction.
// Output stream (m_axis_*): exactly one transaction per input, carrying the
// current median in tdata and, in tuser, a flag that is set when that input
// closed a window and latched a new median.
// Every 64 samples are summed, the sum is shifted right by 3 and its low 16
// bits enter a five-entry window; the fifth value triggers a fixed
// nine-comparator sort and the middle entry becomes the new median.
// An input transaction passes through an input register, the accumulator
// stage and the window/median stage that loads the output register.
// Throughput is one sample per cycle unless the receiver stalls; the
// accumulator add and compare-exchange network each sit in their own stage.
// A stalled receiver holds the output register; the upstream stages keep
// accepting samples until every stage is full, so up to three transactions
// are in flight. Reset empties the pipeline and clears the accumulator,
// the counters and the held median, so the output reads zero until the
// first window completes.
module oversample_median_filter_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,   // [15:0] sample
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [15:0] filtered_value
  output logic                      m_axis_tuser    // [0] median_updated
);
  import omf_pkg::*;

  localparam logic [CNT_W-1:0]    CNT_LAST  = CNT_W'(OVERSAMPLE_COUNT - 1);
  localparam logic [WCOUNT_W-1:0] WIN_LAST  = WCOUNT_W'(WINDOW_LEN - 1);

  // Stage enables.
  logic en1, en2, en3;

  // Input register.
  logic    v1;
  sample_t sample1;

  // Accumulator stage.
  logic [ACC_W-1:0] accumulator;
  logic [CNT_W-1:0] oversample_count;
  logic [ACC_W-1:0] acc_sum;
  logic [ACC_W+SAMPLE_W-1:0] acc_shift;
  logic    v2;
  logic    dec_valid;
  sample_t dec;

  // Window stage.
  sample_t               window_store [WINDOW_LEN-1];
  logic [WCOUNT_W-1:0]   window_count;
  sample_t               median_hold;
  window_t               window;
  sample_t               median;
  logic                  window_done;
  sample_t               median_next;

  // Output register.
  logic    out_valid;
  sample_t out_value;
  logic    out_updated;

  assign en3 = !out_valid || m_axis_tready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_axis_tvalid;
    end
    if (en1 && s_axis_tvalid) begin
      sample1 <= s_axis_tdata;
    end
  end

  assign acc_sum   = accumulator + ACC_W'(sample1);
  assign acc_shift = {{SAMPLE_W{1'b0}}, acc_sum} >> DECIMATE_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator      <= '0;
      oversample_count <= '0;
      v2               <= 1'b0;
      dec_valid        <= 1'b0;
    end else if (en2) begin
      v2        <= v1;
      dec_valid <= v1 && (oversample_count == CNT_LAST);
      if (v1) begin
        if (oversample_count == CNT_LAST) begin
          accumulator      <= '0;
          oversample_count <= '0;
        end else begin
          accumulator      <= acc_sum;
          oversample_count <= oversample_count + 1'b1;
        end
      end
    end
    if (en2 && v1) begin
      dec <= acc_shift[SAMPLE_W-1:0];
    end
  end

  // The fifth value goes straight into the sort; only four are stored.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      window[i] = window_store[i];
    end
    window[WINDOW_LEN-1] = dec;
  end

  omf_median5 u_median (
    .window (window),
    .median (median)
  );

  assign window_done = dec_valid && (window_count == WIN_LAST);
  assign median_next = window_done ? median : median_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      median_hold  <= '0;
    end else if (en3 && v2 && dec_valid) begin
      if (window_done) begin
        window_count <= '0;
        median_hold  <= median;
      end else begin
        window_count <= window_count + 1'b1;
      end
    end
    if (en3 && v2 && dec_valid && !window_done) begin
      window_store[window_count[WIDX_W-1:0]] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
    if (en3 && v2) begin
      out_value   <= median_next;
      out_updated <= window_done;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_updated;

  a_window_count_range: assert property (@(posedge clk) disable iff (rst)
    window_count <= WIN_LAST)
    else $error("window count out of range");

  a_oversample_count_range: assert property (@(posedge clk) disable iff (rst)
    oversample_count <= CNT_LAST)
    else $error("oversample count out of range");

  a_output_tracks_median: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_value == median_hold))
    else $error("output value differs from held median");

  a_no_update_without_decimation: assert property (@(posedge clk) disable iff (rst)
    (en3 && v2 && !dec_valid) |=> (m_axis_tvalid && !m_axis_tuser))
    else $error("median flagged without a decimated value");

  a_update_on_full_window: assert property (@(posedge clk) disable iff (rst)
    (en3 && v2 && dec_valid && (window_count == WIN_LAST))
      |=> (m_axis_tvalid && m_axis_tuser && (window_count == '0)))
    else $error("completed window did not update the median");

endmodule

FILE: src/omf_median5.sv
module omf_median5 (
  input  omf_pkg::window_t window,
  output omf_pkg::sample_t median
);
  import omf_pkg::*;

  window_t w;
  sample_t t;

  always_comb begin
    w = window;
    t = '0;
    for (int i = 0; i < PAIR_CNT; i++) begin
      if (w[PAIR_LO[i]] > w[PAIR_HI[i]]) begin
        t = w[PAIR_LO[i]];
        w[PAIR_LO[i]] = w[PAIR_HI[i]];
        w[PAIR_HI[i]] = t;
      end
    end
    median = w[MEDIAN_POS];
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import omf_pkg::*;

  typedef struct packed {
    sample_t value;
    logic    updated;
  } median_result_t;

  typedef struct packed {
    sample_t     sample;
    logic [15:0] reps;
    logic        fixed_exp;
    sample_t     exp_value;
    logic        exp_updated;
  } stim_row_t;

  typedef enum logic [1:0] {SPREAD_FULL, SPREAD_HIGH, SPREAD_LOW, SPREAD_FLAT} spread_t;

  localparam int STIM_ROWS       = 7;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int RANDOM_ITEMS    = 320;
  localparam int WINDOW_GOAL     = 2;
  localparam int REPORT_LIMIT    = 10;

  // Rows with fixed_exp set carry a typed expectation for every transaction of the row;
  // all other rows are checked against the running prediction.
  localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
    // No window has closed yet, so every output reads zero.
    '{16'h0000, 16'd1,   1'b1, 16'h0000, 1'b0},
    '{16'hFFFF, 16'd63,  1'b1, 16'h0000, 1'b0},
    // A block of 0x8000 samples overflows 16 bits after the shift and wraps to zero.
    '{16'h8000, 16'd64,  1'b1, 16'h0000, 1'b0},
    '{16'h1234, 16'd64,  1'b1, 16'h0000, 1'b0},
    '{16'h7FFF, 16'd64,  1'b1, 16'h0000, 1'b0},
    '{16'h0001, 16'd63,  1'b1, 16'h0000, 1'b0},
    // This sample closes the first window.
    '{16'h0001, 16'd1,   1'b0, 16'h0000, 1'b0}
  };

  logic    clk           = 1'b0;
  logic    rst           = 1'b1;
  logic    s_axis_tvalid = 1'b0;
  logic    s_axis_tready;
  sample_t s_axis_tdata  = '0;
  logic    m_axis_tvalid;
  logic    m_axis_tready = 1'b0;
  sample_t m_axis_tdata;
  logic    m_axis_tuser;

  // Predicted state of the decimator and the median window.
  logic [ACC_W-1:0] acc_sum     = '0;
  int unsigned      blk_count   = 0;
  sample_t          win [WINDOW_LEN] = '{default: '0};
  int unsigned      win_fill    = 0;
  sample_t          median_q    = '0;

  median_result_t   pending_medians [$];
  int unsigned      windows_closed   = 0;
  int unsigned      samples_sent     = 0;
  int unsigned      table_samples    = 0;
  int unsigned      fault_count      = 0;
  int unsigned      backpressure_cyc = 0;
  int unsigned      burst_left       = 0;
  bit               quiet_block      = 1'b0;
  bit               hold_off_req     = 1'b0;

  oversample_median_filter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_medians.size());
    $display("testbench failed");
    $finish;
  end

  function automatic median_result_t predict_median(input sample_t s);
    median_result_t res;
    sample_t        tmp;
    int             i;
    int             j;
    acc_sum = acc_sum + ACC_W'(s);
    blk_count++;
    res.updated = 1'b0;
    if (blk_count == OVERSAMPLE_COUNT) begin
      win[win_fill] = sample_t'(acc_sum >> DECIMATE_SHIFT);
      acc_sum = '0;
      blk_count = 0;
      win_fill++;
      if (win_fill == WINDOW_LEN) begin
        for (i = 1; i < WINDOW_LEN; i++) begin
          tmp = win[i];
          j = i;
          while (j > 0 && win[j-1] > tmp) begin
            win[j] = win[j-1];
            j--;
          end
          win[j] = tmp;
        end
        median_q = win[MEDIAN_POS];
        win_fill = 0;
        res.updated = 1'b1;
        windows_closed++;
      end
    end
    res.value = median_q;
    return res;
  endfunction

  // Sender idle gap; whole oversampling blocks now and then run without gaps.
  function automatic int unsigned next_gap();
    if (blk_count == 0)
      quiet_block = ($urandom_range(0, 3) == 0);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    return quiet_block ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic send_sample(input sample_t s, input int unsigned gap, input bit drain,
                             input bit use_fixed, input median_result_t fixed);
    median_result_t predicted;
    if (drain && gap == 0)
      gap = 1;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      if (drain) begin
        while (pending_medians.size() != 0)
          @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_median(s);
    pending_medians.push_back(use_fixed ? fixed : predicted);
    samples_sent++;
  endtask

  initial begin
    int unsigned    row;
    int unsigned    k;
    int unsigned    rand_count;
    spread_t        spread;
    sample_t        flat_level;
    sample_t        s;
    median_result_t fixed;
    spread = SPREAD_FULL;
    flat_level = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < STIM_ROWS; row++) begin
      fixed.value   = STIM_TABLE[row].exp_value;
      fixed.updated = STIM_TABLE[row].exp_updated;
      for (k = 0; k < STIM_TABLE[row].reps; k++)
        send_sample(STIM_TABLE[row].sample, next_gap(), 1'b0, STIM_TABLE[row].fixed_exp, fixed);
    end
    table_samples = samples_sent;

    rand_count = 0;
    while (rand_count < RANDOM_ITEMS || windows_closed < WINDOW_GOAL) begin
      if (blk_count == 0) begin
        spread = spread_t'($urandom_range(0, 3));
        flat_level = $urandom_range(0, 16'hFFFF);
      end
      case (spread)
        SPREAD_FULL: s = $urandom_range(0, 16'hFFFF);
        SPREAD_HIGH: s = $urandom_range(16'hE000, 16'hFFFF);
        SPREAD_LOW:  s = $urandom_range(0, 16'h0FFF);
        default:     s = flat_level;
      endcase
      // Stall the output for a long stretch while samples keep arriving back to back.
      if (rand_count == 150 || rand_count == 260) begin
        hold_off_req = 1'b1;
        burst_left = 30;
      end
      send_sample(s, next_gap(), rand_count == 0 || rand_count == 200, 1'b0, fixed);
      rand_count++;
    end
    s_axis_tvalid <= 1'b0;

    for (k = 0; k < 2000 && pending_medians.size() != 0; k++)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_medians.size() != 0) begin
      $display("%0d expected results never arrived", pending_medians.size());
      fault_count += pending_medians.size();
    end

    $display("Streamed %0d samples (%0d from the directed table), %0d median windows closed.",
             samples_sent, table_samples, windows_closed);
    $display("Input was back-pressured for %0d cycles; %0d faults seen.",
             backpressure_cyc, fault_count);
    if (fault_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned served;
    bit          calm;
    served = 0;
    calm = 1'b0;
    while (rst)
      @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (served % 40 == 0)
        calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      served++;
    end
  end

  // Each output transaction is checked against the oldest pending expectation.
  always @(posedge clk) begin : result_check
    median_result_t want;
    if (!rst && s_axis_tvalid && !s_axis_tready)
      backpressure_cyc++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_medians.size() == 0) begin
        if (fault_count < REPORT_LIMIT)
          $display("unexpected result: value %h updated %b", m_axis_tdata, m_axis_tuser);
        fault_count++;
      end else begin
        want = pending_medians.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser !== want.updated) begin
          if (fault_count < REPORT_LIMIT)
            $display("mismatch: expected value %h updated %b, got value %h updated %b",
                     want.value, want.updated, m_axis_tdata, m_axis_tuser);
          fault_count++;
        end
      end
    end
  end

endmodule

FILE: oversample_median_filter_unit.f
src/omf_pkg.sv
src/omf_median5.sv
src/oversample_median_filter_unit.sv
verif/testbench.sv
